>>> rtl/core/afd_pkg.sv
// Package for the accelerometer fall detector core.
// Holds field widths, status codes, register indexes and the pipeline control struct.
// No dependencies.
package afd_pkg;

  // Fixed widths of the sample ports and the configuration registers.
  localparam int ACCEL_W = 16;
  localparam int CFG_W   = 34;
  localparam int CFG_IDX_W = 2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_FALL_THR   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMPACT_THR = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STILL_MIN  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STILL_MAX  = 2'd3;

  // Status code reported with every result.
  typedef enum logic [2:0] {
    STAT_WARMUP        = 3'd0,
    STAT_REST          = 3'd1,
    STAT_FALL_START    = 3'd2,
    STAT_FALLING       = 3'd3,
    STAT_IMPACT        = 3'd4,
    STAT_NO_CONFIRM    = 3'd5,
    STAT_ALARM_ENTERED = 3'd6,
    STAT_ALARM_HELD    = 3'd7
  } status_t;

  // Per-stage pipeline control: global advance and the incoming stage valid.
  typedef struct packed {
    logic advance;
    logic valid;
  } pipe_ctl_t;

endpackage

>>> rtl/core/accel_fall_detector_core.sv
// Top level of the accelerometer fall detector: magnitude unit, window cells, control.
// Depends on afd_pkg, afd_mag, afd_cell and afd_ctrl.
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+---------------------------------
//   in      | input     | in_valid / in_stall | in_accel_x, in_accel_y, in_accel_z
//   out     | output    | out_valid/out_stall | out_status, out_window_sum
//   cfg     | input     | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// One sample per cycle while the output is not stalled; each result is registered through
// the square at the accepting edge, then the magnitude sum, the window update, and the state
// machine plus output register. The window is a chain of cells that shifts once per sample.
// Synchronous active-low reset clears the window, sum, warmup counter, state, valid flags and
// configuration registers. A stalled result freezes the whole pipeline; in_stall follows
// out_stall while a result is held. Configuration writes are always ready.
module accel_fall_detector_core
  import afd_pkg::*;
#(
  parameter int WINDOW      = 5,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [ACCEL_W-1:0]   in_accel_x,
  input  logic [ACCEL_W-1:0]   in_accel_y,
  input  logic [ACCEL_W-1:0]   in_accel_z,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [2:0]           out_status,
  output logic [CFG_W-1:0]     out_window_sum,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam int MAG_W   = 2 * SAMPLE_BITS;
  localparam int RAW_W   = MAG_W + $clog2(WINDOW);
  localparam int SUM_W   = (RAW_W > CFG_W) ? RAW_W : CFG_W;

  logic             advance;
  pipe_ctl_t        mag_ctl, ctrl_ctl;
  logic             mag_valid;
  logic [MAG_W-1:0] mag;
  logic [MAG_W-1:0] tap [WINDOW];
  logic             shift_en;
  logic [SUM_W-1:0] sum_r, sum_nxt;
  logic             sum_valid_r;
  logic [CFG_W-1:0] fall_thr_r, impact_thr_r, still_min_r, still_max_r;
  logic             alarm;

  // The pipeline moves unless a finished result is waiting to be taken.
  assign advance  = !(out_valid && out_stall);
  assign in_stall = !advance;
  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fall_thr_r   <= '0;
      impact_thr_r <= '0;
      still_min_r  <= '0;
      still_max_r  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_FALL_THR:   fall_thr_r   <= cfg_data;
        REG_IMPACT_THR: impact_thr_r <= cfg_data;
        REG_STILL_MIN:  still_min_r  <= cfg_data;
        REG_STILL_MAX:  still_max_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Squared magnitude of each sample.
  assign mag_ctl = '{advance: advance, valid: in_valid};

  afd_mag #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_mag (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (mag_ctl),
    .accel_x  (in_accel_x),
    .accel_y  (in_accel_y),
    .accel_z  (in_accel_z),
    .mag_valid(mag_valid),
    .mag      (mag)
  );

  // Window of magnitudes as a chain of cells; the last cell holds the oldest value.
  assign shift_en = advance && mag_valid;

  for (genvar g = 0; g < WINDOW; g++) begin : g_cell
    if (g == 0) begin : g_head
      afd_cell #(.DATA_W(MAG_W)) u_cell (
        .clk     (clk),
        .rst_n   (rst_n),
        .shift_en(shift_en),
        .d_in    (mag),
        .q       (tap[g])
      );
    end else begin : g_body
      afd_cell #(.DATA_W(MAG_W)) u_cell (
        .clk     (clk),
        .rst_n   (rst_n),
        .shift_en(shift_en),
        .d_in    (tap[g-1]),
        .q       (tap[g])
      );
    end
  end

  // Moving sum: add the new magnitude, drop the one leaving the window.
  assign sum_nxt = sum_r + SUM_W'(mag) - SUM_W'(tap[WINDOW-1]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r       <= '0;
      sum_valid_r <= 1'b0;
    end else if (advance) begin
      sum_valid_r <= mag_valid;
      if (mag_valid) begin
        sum_r <= sum_nxt;
      end
    end
  end

  // Detection state machine and result register.
  assign ctrl_ctl = '{advance: advance, valid: sum_valid_r};

  afd_ctrl #(
    .WINDOW(WINDOW),
    .SUM_W (SUM_W)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctrl_ctl),
    .sum       (sum_r),
    .fall_thr  (fall_thr_r),
    .impact_thr(impact_thr_r),
    .still_min (still_min_r),
    .still_max (still_max_r),
    .out_valid (out_valid),
    .out_status(out_status),
    .out_sum   (out_window_sum),
    .alarm     (alarm)
  );

`ifndef ASSERT_OFF
  // Once in alarm, the block never leaves it before reset.
  a_alarm_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    $past(alarm) |-> alarm)
    else $error("alarm state was left without reset");

  // An alarm status in the output register implies the state machine is in alarm.
  a_alarm_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == STAT_ALARM_ENTERED || out_status == STAT_ALARM_HELD))
      |-> alarm)
    else $error("alarm status reported outside the alarm state");

  // A held result freezes the window sum.
  a_sum_frozen: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> $stable(sum_r))
    else $error("window sum moved while the output was stalled");
`endif

endmodule

>>> rtl/core/afd_mag.sv
// Squared-magnitude unit: squares the three axes, then sums them (two stages).
// Depends on afd_pkg.
module afd_mag
  import afd_pkg::*;
#(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  pipe_ctl_t                ctl,
  input  logic [ACCEL_W-1:0]       accel_x,
  input  logic [ACCEL_W-1:0]       accel_y,
  input  logic [ACCEL_W-1:0]       accel_z,
  output logic                     mag_valid,
  output logic [2*SAMPLE_BITS-1:0] mag
);

  localparam int MAG_W = 2 * SAMPLE_BITS;

  logic signed [SAMPLE_BITS-1:0] sx, sy, sz;
  logic [MAG_W-1:0] sq_x_r, sq_y_r, sq_z_r;
  logic [MAG_W-1:0] mag_r;
  logic             sq_valid_r, mag_valid_r;

  // Only the low sample bits are used, taken as two's complement.
  assign sx = accel_x[SAMPLE_BITS-1:0];
  assign sy = accel_y[SAMPLE_BITS-1:0];
  assign sz = accel_z[SAMPLE_BITS-1:0];

  // Stage valids.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_valid_r  <= 1'b0;
      mag_valid_r <= 1'b0;
    end else if (ctl.advance) begin
      sq_valid_r  <= ctl.valid;
      mag_valid_r <= sq_valid_r;
    end
  end

  // Squares are non-negative and fit in MAG_W bits; so does their sum.
  // The operands are sign extended to the full product width first.
  always_ff @(posedge clk) begin
    if (ctl.advance) begin
      sq_x_r <= $unsigned(MAG_W'(sx) * MAG_W'(sx));
      sq_y_r <= $unsigned(MAG_W'(sy) * MAG_W'(sy));
      sq_z_r <= $unsigned(MAG_W'(sz) * MAG_W'(sz));
      mag_r  <= sq_x_r + sq_y_r + sq_z_r;
    end
  end

  assign mag_valid = mag_valid_r;
  assign mag       = mag_r;

endmodule

>>> rtl/core/afd_cell.sv
// One cell of the magnitude window: holds one magnitude, passes it on each shift.
// No dependencies.
module afd_cell #(
  parameter int DATA_W = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              shift_en,
  input  logic [DATA_W-1:0] d_in,
  output logic [DATA_W-1:0] q
);

  logic [DATA_W-1:0] data_r;

  // The window starts cleared, so the cell resets to zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      data_r <= '0;
    end else if (shift_en) begin
      data_r <= d_in;
    end
  end

  assign q = data_r;

endmodule

>>> rtl/core/afd_ctrl.sv
// Detection state machine with warmup counter and the result output register.
// Depends on afd_pkg.
module afd_ctrl
  import afd_pkg::*;
#(
  parameter int WINDOW = 5,
  parameter int SUM_W  = 35
) (
  input  logic             clk,
  input  logic             rst_n,
  input  pipe_ctl_t        ctl,
  input  logic [SUM_W-1:0] sum,
  input  logic [CFG_W-1:0] fall_thr,
  input  logic [CFG_W-1:0] impact_thr,
  input  logic [CFG_W-1:0] still_min,
  input  logic [CFG_W-1:0] still_max,
  output logic             out_valid,
  output logic [2:0]       out_status,
  output logic [CFG_W-1:0] out_sum,
  output logic             alarm
);

  localparam int WARM_W = $clog2(WINDOW + 2);

  typedef enum logic [1:0] {
    FSM_REST,
    FSM_FALLING,
    FSM_IMPACTED,
    FSM_ALARM
  } fsm_t;

  fsm_t              state_r, state_nxt;
  logic [WARM_W-1:0] warm_cnt_r, warm_cnt_nxt;
  status_t           status_nxt;
  status_t           status_r;
  logic              out_valid_r;
  logic [CFG_W-1:0]  out_sum_r;
  logic [SUM_W-1:0]  fall_ext, impact_ext, min_ext, max_ext;

  assign fall_ext   = SUM_W'(fall_thr);
  assign impact_ext = SUM_W'(impact_thr);
  assign min_ext    = SUM_W'(still_min);
  assign max_ext    = SUM_W'(still_max);

  // Next state and status for the sum arriving this cycle.
  always_comb begin
    state_nxt    = state_r;
    warm_cnt_nxt = warm_cnt_r;
    status_nxt   = STAT_WARMUP;
    if (warm_cnt_r <= WARM_W'(WINDOW)) begin
      warm_cnt_nxt = warm_cnt_r + 1'b1;
    end else begin
      case (state_r)
        FSM_REST: begin
          if (sum < fall_ext) begin
            state_nxt  = FSM_FALLING;
            status_nxt = STAT_FALL_START;
          end else begin
            status_nxt = STAT_REST;
          end
        end
        FSM_FALLING: begin
          if (sum < impact_ext) begin
            state_nxt  = FSM_IMPACTED;
            status_nxt = STAT_IMPACT;
          end else begin
            status_nxt = STAT_FALLING;
          end
        end
        FSM_IMPACTED: begin
          if (sum < max_ext && sum > min_ext) begin
            state_nxt  = FSM_ALARM;
            status_nxt = STAT_ALARM_ENTERED;
          end else begin
            status_nxt = STAT_NO_CONFIRM;
          end
        end
        default: begin
          state_nxt  = FSM_ALARM;
          status_nxt = STAT_ALARM_HELD;
        end
      endcase
    end
  end

  // State, warmup count and the registered result.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= FSM_REST;
      warm_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else if (ctl.advance) begin
      out_valid_r <= ctl.valid;
      if (ctl.valid) begin
        state_r    <= state_nxt;
        warm_cnt_r <= warm_cnt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.advance && ctl.valid) begin
      status_r  <= status_nxt;
      out_sum_r <= sum[CFG_W-1:0];
    end
  end

  assign out_valid  = out_valid_r;
  assign out_status = status_r;
  assign out_sum    = out_sum_r;
  assign alarm      = (state_r == FSM_ALARM);

endmodule
